[hdl/mrf_pkg.sv]
`timescale 1ns / 1ps

package mrf_pkg;

  // Modbus function codes.
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  // CRC-16 (Modbus): reflected polynomial, all-ones start value.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_START = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'd10;
  localparam logic [15:0] READ_START_RST  = 16'd0;
  localparam logic [15:0] WRITE_START_RST = 16'd0;

  // Depth of the queue between the classifier and the byte sequencer.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // What a queued item asks the byte sequencer to emit.
  typedef enum logic [1:0] {
    KIND_READ,        // full read request frame
    KIND_WRITE_HEAD,  // write header, byte count and first word
    KIND_WRITE_DATA   // one further write word
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        close;  // append the CRC after this item's bytes
    logic [6:0]  count;
    logic [15:0] value;
  } entry_t;

  // Fold one byte into the running CRC, one bit per step.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hdl/mrf_front.sv]
`timescale 1ns / 1ps

module mrf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  logic [6:0]     reg_count_i,
  input  logic [15:0]    reg_value_i,
  output logic           q_push_o,
  input  logic           q_ready_i,
  output mrf_pkg::entry_t q_entry_o
);
  import mrf_pkg::*;

  logic [6:0] words_left_q, words_left_d;
  logic       accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign q_push_o   = accept;

  // Classify the item against the open write frame, if any.
  always_comb begin
    words_left_d      = words_left_q;
    q_entry_o.count   = reg_count_i;
    q_entry_o.value   = reg_value_i;
    if (words_left_q != 7'd0) begin
      q_entry_o.kind  = KIND_WRITE_DATA;
      q_entry_o.close = (words_left_q == 7'd1);
      if (accept) words_left_d = words_left_q - 7'd1;
    end else if (!req_type_i) begin
      q_entry_o.kind  = KIND_READ;
      q_entry_o.close = 1'b1;
    end else begin
      q_entry_o.kind  = KIND_WRITE_HEAD;
      q_entry_o.close = (reg_count_i <= 7'd1);
      if (accept && reg_count_i != 7'd0) words_left_d = reg_count_i - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= 7'd0;
    end else begin
      words_left_q <= words_left_d;
    end
  end

endmodule

[hdl/mrf_queue.sv]
`timescale 1ns / 1ps

module mrf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  mrf_pkg::entry_t entry_i,
  output logic            valid_o,
  input  logic            pop_i,
  output mrf_pkg::entry_t entry_o
);
  import mrf_pkg::*;

  entry_t                 slots_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] fill_q;

  assign ready_o = (fill_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  // Pointer wrap for a depth that need not be a power of two.
  function automatic logic [QUEUE_PTR_W-1:0] bump(logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= bump(rd_ptr_q);
      if (push_i && !pop_i)      fill_q <= fill_q + 1'b1;
      else if (pop_i && !push_i) fill_q <= fill_q - 1'b1;
    end
  end

  // Storage is payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= entry_i;
  end

endmodule

[hdl/mrf_back.sv]
`timescale 1ns / 1ps

module mrf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      slave_address_i,
  input  logic [15:0]     read_start_address_i,
  input  logic [15:0]     write_start_address_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  mrf_pkg::entry_t q_entry_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      frame_byte_o,
  output logic            frame_end_o
);
  import mrf_pkg::*;

  typedef enum logic [3:0] {
    STEP_ADDR,
    STEP_FUNC,
    STEP_SA_HI,
    STEP_SA_LO,
    STEP_CNT_HI,
    STEP_CNT_LO,
    STEP_BCNT,
    STEP_VAL_HI,
    STEP_VAL_LO,
    STEP_CRC_LO,
    STEP_CRC_HI
  } step_e;

  step_e       step_q, step_nxt;
  entry_t      cur_q;
  logic        active_q;
  logic [15:0] crc_q, crc_base, crc_upd;
  logic        out_valid_q, frame_end_q;
  logic [7:0]  frame_byte_q;
  logic [7:0]  byte_nxt;
  logic [15:0] start_addr;
  logic        is_crc, is_end, done;
  logic        advance, load;

  assign start_addr = (cur_q.kind == KIND_READ) ? read_start_address_i
                                                : write_start_address_i;

  // Byte selection and successor step for the current position in the frame.
  always_comb begin
    byte_nxt = 8'h00;
    step_nxt = step_q;
    is_crc   = 1'b0;
    is_end   = 1'b0;
    done     = 1'b0;
    case (step_q)
      STEP_ADDR: begin
        byte_nxt = slave_address_i;
        step_nxt = STEP_FUNC;
      end
      STEP_FUNC: begin
        byte_nxt = (cur_q.kind == KIND_READ) ? FC_READ_HOLDING : FC_WRITE_MULTI;
        step_nxt = STEP_SA_HI;
      end
      STEP_SA_HI: begin
        byte_nxt = start_addr[15:8];
        step_nxt = STEP_SA_LO;
      end
      STEP_SA_LO: begin
        byte_nxt = start_addr[7:0];
        step_nxt = STEP_CNT_HI;
      end
      STEP_CNT_HI: begin
        byte_nxt = 8'h00;
        step_nxt = STEP_CNT_LO;
      end
      STEP_CNT_LO: begin
        byte_nxt = {1'b0, cur_q.count};
        step_nxt = (cur_q.kind == KIND_READ) ? STEP_CRC_LO : STEP_BCNT;
      end
      STEP_BCNT: begin
        byte_nxt = {cur_q.count, 1'b0};
        step_nxt = (cur_q.count == 7'd0) ? STEP_CRC_LO : STEP_VAL_HI;
      end
      STEP_VAL_HI: begin
        byte_nxt = cur_q.value[15:8];
        step_nxt = STEP_VAL_LO;
      end
      STEP_VAL_LO: begin
        byte_nxt = cur_q.value[7:0];
        step_nxt = STEP_CRC_LO;
        done     = !cur_q.close;
      end
      STEP_CRC_LO: begin
        byte_nxt = crc_q[7:0];
        is_crc   = 1'b1;
        step_nxt = STEP_CRC_HI;
      end
      STEP_CRC_HI: begin
        byte_nxt = crc_q[15:8];
        is_crc   = 1'b1;
        is_end   = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Every frame starts its CRC from the initial value.
  assign crc_base = (step_q == STEP_ADDR) ? CRC_INIT : crc_q;
  assign crc_upd  = crc16_byte(crc_base, byte_nxt);

  // One byte per cycle whenever the output register is free or being drained.
  assign advance = active_q && (!out_valid_q || out_ready_i);
  assign load    = q_valid_i && (!active_q || (advance && done));
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      step_q       <= STEP_ADDR;
      cur_q        <= '0;
      crc_q        <= CRC_INIT;
      out_valid_q  <= 1'b0;
      frame_byte_q <= 8'h00;
      frame_end_q  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q  <= 1'b1;
        frame_byte_q <= byte_nxt;
        frame_end_q  <= is_end;
        if (is_end)       crc_q <= CRC_INIT;
        else if (!is_crc) crc_q <= crc_upd;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (load) begin
        active_q <= 1'b1;
        cur_q    <= q_entry_i;
        step_q   <= (q_entry_i.kind == KIND_WRITE_DATA) ? STEP_VAL_HI : STEP_ADDR;
      end else if (advance) begin
        if (done) active_q <= 1'b0;
        step_q <= step_nxt;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign frame_end_o  = frame_end_q;

  // A new transaction is taken from the queue only between items.
  a_pop_between_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_valid_i && (!active_q || (advance && done))))
    else $error("queue popped while an item is still being sequenced");

  // Closing a frame leaves the CRC at its start value.
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_q == STEP_CRC_HI) |=> (crc_q == CRC_INIT))
    else $error("CRC not restarted after frame end");

  // Header-only steps are reached only by items that carry a header.
  a_header_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && (step_q == STEP_ADDR || step_q == STEP_BCNT))
      |-> (cur_q.kind != KIND_WRITE_DATA))
    else $error("data word item reached a header step");

  // A frame end byte comes only from a closing item.
  a_end_needs_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_end) |-> cur_q.close)
    else $error("frame end emitted by an item that does not close the frame");

endmodule

[hdl/modbus_rtu_request_framer.sv]
`timescale 1ns / 1ps

// Modbus RTU request framer: turns request items into the frame byte stream,
// one byte per output transaction, CRC-16 appended low byte first and
// frame_end_o marking the CRC high byte. A read request is one item and yields
// 8 bytes; a write request takes one item per register word, the first item
// yielding the 7-byte header plus its word if any, each later item its 2-byte
// word, and the closing item 2 CRC bytes more. The byte sequencer emits one
// byte per cycle while out_ready_i does not hold it off, so an item occupies
// it until its bytes have left. A two-entry queue lets the input side accept
// items while the sequencer is busy; an accepted item is registered in the
// queue, then in the sequencer, before its first byte reaches the output
// register. Configuration writes are always accepted and take effect at once;
// write them only while no frame is in flight.
module modbus_rtu_request_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mrf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [6:0]                      reg_count_i,
  input  logic [15:0]                     reg_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      frame_byte_o,
  output logic                            frame_end_o
);
  import mrf_pkg::*;

  logic [7:0]  slave_address_q;
  logic [15:0] read_start_address_q, write_start_address_q;
  logic        q_push, q_ready, q_valid, q_pop;
  entry_t      push_entry, pop_entry;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q       <= SLAVE_ADDR_RST;
      read_start_address_q  <= READ_START_RST;
      write_start_address_q <= WRITE_START_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLAVE_ADDR:  slave_address_q       <= cfg_data_i[7:0];
        CFG_READ_START:  read_start_address_q  <= cfg_data_i;
        CFG_WRITE_START: write_start_address_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .reg_count_i (reg_count_i),
    .reg_value_i (reg_value_i),
    .q_push_o    (q_push),
    .q_ready_i   (q_ready),
    .q_entry_o   (push_entry)
  );

  mrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .entry_i (push_entry),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (pop_entry)
  );

  mrf_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .slave_address_i       (slave_address_q),
    .read_start_address_i  (read_start_address_q),
    .write_start_address_i (write_start_address_q),
    .q_valid_i             (q_valid),
    .q_pop_o               (q_pop),
    .q_entry_i             (pop_entry),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .frame_byte_o          (frame_byte_o),
    .frame_end_o           (frame_end_o)
  );

endmodule

[tb/modbus_rtu_request_framer_tb.sv]
`timescale 1ns / 1ps

module modbus_rtu_request_framer_tb;
  import mrf_pkg::*;

  // Request types as carried on req_type_i.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Frame constants used by the expected-byte generator.
  localparam logic [7:0]  FN_READ_HOLDING = 8'd3;
  localparam logic [7:0]  FN_WRITE_MULTI  = 8'd16;
  localparam logic [15:0] CRC_SEED        = 16'hFFFF;
  localparam logic [15:0] CRC_REFL_POLY   = 16'hA001;

  localparam int RANDOM_ITEMS = 280;
  localparam int NUM_PHASES   = 5;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_TRICKLE} sink_mode_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [15:0]            cdata;
    logic                   rtype;
    logic [6:0]             count;
    logic [15:0]            value;
    logic                   typed;  // frame below replaces the computed bytes
    logic [63:0]            frame;  // first byte in the top bits
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_SLAVE_ADDR;
  logic [15:0]          cfg_data_i  = 16'h0000;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i  = REQ_READ;
  logic [6:0]           reg_count_i = 7'd0;
  logic [15:0]          reg_value_i = 16'h0000;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           frame_byte_o;
  logic                 frame_end_o;

  // Shadow of the block's configuration and frame state.
  logic [7:0]  shadow_slave;
  logic [15:0] shadow_rd_start;
  logic [15:0] shadow_wr_start;
  logic [15:0] crc_acc;
  logic [6:0]  words_pending;

  frame_byte_t frame_bytes_due [$];
  stim_row_t   directed_rows [$];
  int          err_count  = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          steady     = 1'b0;

  modbus_rtu_request_framer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .reg_count_i  (reg_count_i),
    .reg_value_i  (reg_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

  always #1 clk_i = ~clk_i;

  // Fold one byte into a Modbus CRC-16, least significant bit first.
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_REFL_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  task automatic due_push(logic [7:0] b, logic last);
    frame_bytes_due.push_back('{data: b, last: last});
  endtask

  task automatic due_push_crc(logic [7:0] b);
    crc_acc = crc_fold(crc_acc, b);
    due_push(b, 1'b0);
  endtask

  task automatic due_push_word(logic [15:0] w);
    due_push_crc(w[15:8]);
    due_push_crc(w[7:0]);
  endtask

  task automatic due_push_close();
    due_push(crc_acc[7:0], 1'b0);
    due_push(crc_acc[15:8], 1'b1);
    crc_acc       = CRC_SEED;
    words_pending = '0;
  endtask

  // Queue the frame bytes that one accepted request transaction produces.
  task automatic frame_predict(logic rtype, logic [6:0] count, logic [15:0] value);
    // An open write frame takes the transaction as its next word, whatever it asks.
    if (words_pending != 0) begin
      due_push_word(value);
      words_pending = words_pending - 7'd1;
      if (words_pending == 0) begin
        due_push_close();
      end
      return;
    end
    crc_acc = CRC_SEED;
    due_push_crc(shadow_slave);
    if (rtype == REQ_READ) begin
      due_push_crc(FN_READ_HOLDING);
      due_push_word(shadow_rd_start);
      due_push_word({9'd0, count});
      due_push_close();
    end else begin
      due_push_crc(FN_WRITE_MULTI);
      due_push_word(shadow_wr_start);
      due_push_word({9'd0, count});
      due_push_crc({count, 1'b0});
      if (count == 0) begin
        due_push_close();
      end else begin
        due_push_word(value);
        words_pending = count - 7'd1;
        if (words_pending == 0) begin
          due_push_close();
        end
      end
    end
  endtask

  function automatic stim_row_t row_item(logic rtype, logic [6:0] count, logic [15:0] value);
    return '{kind: ROW_ITEM, idx: CFG_SLAVE_ADDR, cdata: 16'h0000, rtype: rtype,
             count: count, value: value, typed: 1'b0, frame: 64'h0};
  endfunction

  function automatic stim_row_t row_frame(logic [6:0] count, logic [63:0] frame);
    return '{kind: ROW_ITEM, idx: CFG_SLAVE_ADDR, cdata: 16'h0000, rtype: REQ_READ,
             count: count, value: 16'h0000, typed: 1'b1, frame: frame};
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    return '{kind: ROW_CFG, idx: idx, cdata: d, rtype: REQ_READ, count: 7'd0,
             value: 16'h0000, typed: 1'b0, frame: 64'h0};
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    if (steady) begin
      return;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Present one request transaction and wait until it is taken.
  task automatic send_item(logic rtype, logic [6:0] count, logic [15:0] value);
    in_valid_i  <= 1'b1;
    req_type_i  <= rtype;
    reg_count_i <= count;
    reg_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    frame_predict(rtype, count, value);
    items_sent++;
    pace();
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SLAVE_ADDR:  shadow_slave    = d[7:0];
      CFG_READ_START:  shadow_rd_start = d;
      CFG_WRITE_START: shadow_wr_start = d;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Drain every outstanding byte, then give the block spare idle cycles.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // One complete write frame: header transaction, then the remaining words.
  task automatic send_write_frame(logic [6:0] count);
    send_item(REQ_WRITE, count, 16'($urandom()));
    for (int k = 1; k < count; k++) begin
      // Type and count are ignored inside an open frame, so they carry noise.
      send_item(1'($urandom()), 7'($urandom()), 16'($urandom()));
    end
  endtask

  // Receiver readiness follows a mode that is redrawn at random intervals.
  sink_mode_e sink_mode = SINK_OPEN;
  int         sink_left = 0;
  int         sink_tick = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 80);
      end else begin
        sink_left--;
      end
      sink_tick++;
      case (sink_mode)
        SINK_OPEN:    out_ready_i <= 1'b1;
        SINK_COIN:    out_ready_i <= 1'($urandom());
        SINK_COMB:    out_ready_i <= ((sink_tick % 5) < 3);
        SINK_TRICKLE: out_ready_i <= ($urandom_range(0, 5) == 0);
        default:      out_ready_i <= 1'b1;
      endcase
    end
  end

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_bytes_due.size() == 0) begin
        $error("frame_byte: no byte expected, actual %02h (frame_end %0b)",
               frame_byte_o, frame_end_o);
        err_count++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_byte_o !== want.data) begin
          $error("frame_byte: expected %02h, actual %02h", want.data, frame_byte_o);
          err_count++;
        end
        if (frame_end_o !== want.last) begin
          $error("frame_end: expected %0b, actual %0b", want.last, frame_end_o);
          err_count++;
        end
      end
    end
  end

  // Stimulus: directed table first, then random frames over several settings.
  initial begin
    stim_row_t   row;
    int          target;
    int          pick;
    bit          big_done;
    logic [15:0] hi_lo;

    shadow_slave    = SLAVE_ADDR_RST;
    shadow_rd_start = READ_START_RST;
    shadow_wr_start = WRITE_START_RST;
    crc_acc         = CRC_SEED;
    words_pending   = '0;
    big_done        = 1'b0;

    directed_rows.push_back(row_item(REQ_READ, 7'd1, 16'h0000));
    directed_rows.push_back(row_cfg(CFG_SLAVE_ADDR, 16'h0011));
    directed_rows.push_back(row_cfg(CFG_READ_START, 16'h006B));
    directed_rows.push_back(row_frame(7'd3, 64'h11_03_00_6B_00_03_76_87));
    directed_rows.push_back(row_cfg(CFG_SLAVE_ADDR, 16'h0001));
    directed_rows.push_back(row_cfg(CFG_READ_START, 16'h0000));
    directed_rows.push_back(row_frame(7'd10, 64'h01_03_00_00_00_0A_C5_CD));
    // Zero count read, then the widest count.
    directed_rows.push_back(row_item(REQ_READ, 7'd0, 16'hFFFF));
    directed_rows.push_back(row_item(REQ_READ, 7'd127, 16'hFFFF));
    // Zero count write closes at once; a single-word write closes in its header.
    directed_rows.push_back(row_item(REQ_WRITE, 7'd0, 16'hFFFF));
    directed_rows.push_back(row_item(REQ_WRITE, 7'd1, 16'hFFFF));
    directed_rows.push_back(row_cfg(CFG_SLAVE_ADDR, 16'hFFFF));
    directed_rows.push_back(row_cfg(CFG_READ_START, 16'hFFFF));
    directed_rows.push_back(row_cfg(CFG_WRITE_START, 16'hFFFF));
    // Inside an open write frame a read request is taken as a data word.
    directed_rows.push_back(row_item(REQ_WRITE, 7'd3, 16'h0000));
    directed_rows.push_back(row_item(REQ_READ, 7'd0, 16'hA5A5));
    directed_rows.push_back(row_item(REQ_WRITE, 7'd127, 16'h5A5A));
    directed_rows.push_back(row_item(REQ_READ, 7'h55, 16'h0000));
    directed_rows.push_back(row_cfg(CFG_SLAVE_ADDR, 16'h0000));
    directed_rows.push_back(row_cfg(CFG_WRITE_START, 16'h0000));
    directed_rows.push_back(row_item(REQ_WRITE, 7'd2, 16'h8001));
    directed_rows.push_back(row_item(REQ_WRITE, 7'd64, 16'h7FFE));
    directed_rows.push_back(row_item(REQ_READ, 7'h2A, 16'h0000));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        cfg_write(row.idx, row.cdata);
      end else begin
        send_item(row.rtype, row.count, row.value);
        if (row.typed) begin
          // A read frame is eight bytes; its known form replaces the computed one.
          repeat (8) void'(frame_bytes_due.pop_back());
          for (int k = 0; k < 8; k++) begin
            due_push(row.frame[63 - 8*k -: 8], k == 7);
          end
        end
      end
    end

    target = items_sent;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        1: begin
          cfg_write(CFG_SLAVE_ADDR, 16'h0000);
          cfg_write(CFG_READ_START, 16'h0000);
          cfg_write(CFG_WRITE_START, 16'h0000);
        end
        2: begin
          cfg_write(CFG_SLAVE_ADDR, 16'h00FF);
          cfg_write(CFG_READ_START, 16'hFFFF);
          cfg_write(CFG_WRITE_START, 16'hFFFF);
        end
        default: begin
          cfg_write(CFG_SLAVE_ADDR, 16'($urandom()));
          cfg_write(CFG_READ_START, 16'($urandom()));
          cfg_write(CFG_WRITE_START, 16'($urandom()));
        end
      endcase
      // The fourth phase runs the sender without gaps.
      steady = (ph == 3);
      target += RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) begin
        pick = $urandom_range(0, 11);
        if (pick < 4) begin
          send_item(REQ_READ, 7'($urandom()), 16'($urandom()));
        end else if (pick < 9) begin
          if (ph == 2 && !big_done) begin
            big_done = 1'b1;
            send_write_frame(7'($urandom_range(64, 100)));
          end else begin
            send_write_frame(7'($urandom_range(1, 8)));
          end
        end else if (pick < 10) begin
          // Zero count write with random word bits.
          hi_lo = 16'($urandom());
          send_item(REQ_WRITE, 7'd0, hi_lo);
        end else begin
          send_write_frame(7'($urandom_range(1, 2)));
        end
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** modbus_rtu_request_framer: PASSED **");
    end else begin
      $display("** modbus_rtu_request_framer: FAILED **");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #600000;
    $display("** modbus_rtu_request_framer: FAILED **");
    $finish;
  end

endmodule
